### hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");

`endif

### hdl/pip_pkg.sv
`default_nettype none
package pip_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 32;

   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int VERT_W = 2 * COORD_BITS;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [1:0]                   action;
      logic signed [COORD_BITS-1:0] coord_x;
      logic signed [COORD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic             inside_res;
      logic [CNT_W-1:0] vertex_count;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic first;
   } edge_ctrl_type;

   typedef struct packed {
      logic pending;
      logic parity;
   } edge_status_type;

endpackage
`default_nettype wire

### hdl/point_in_polygon_test.sv
// Channel   | Ports                         | Transfer
// ----------+-------------------------------+------------------------------------
// request   | start, busy, req_data         | rising edge with start high, busy low
// response  | rsp_strobe, rsp_data          | rising edge ending the strobe cycle
//
// Add, clear and unused codes answer in the cycle after the transfer; busy stays low.
// A query on n >= 2 vertices makes n + 1 vertex reads from the vertex RAM, one per
// cycle, then passes the three-stage edge pipe and the response register; busy
// stays high until the response is registered.
// A query on fewer than two vertices answers in the cycle after the transfer.
// Reset is synchronous and clears the count; the RAM contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module point_in_polygon_test (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pip_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pip_pkg::rsp_type rsp_data
);
   import pip_pkg::*;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic signed [COORD_BITS-1:0] pt_x_ff, pt_x_in;
   logic signed [COORD_BITS-1:0] pt_y_ff, pt_y_in;
   logic rd_vld_ff, rd_first_ff;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [VERT_W-1:0] rd_data;
   logic [CNT_W-1:0]  last_idx;
   logic              edge_clear;

   edge_ctrl_type   edge_ctrl;
   edge_status_type edge_status;

   assign last_idx = count_ff - ONE;

   // Sequencer: decode the transfer, walk the table, wait for the edge pipe.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      pt_x_in        = pt_x_ff;
      pt_y_in        = pt_y_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = idx_ff[ADDR_W-1:0];
      edge_clear     = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_in.inside_res   = 1'b0;
      rsp_in.vertex_count = count_ff;
      rsp_in.overflow     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pt_x_in = req_data.coord_x;
               pt_y_in = req_data.coord_y;
               unique case (req_data.action)
                  ACT_ADD: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff < MAX_COUNT) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + ONE;
                     end else begin
                        rsp_in.overflow = 1'b1;
                     end
                     rsp_in.vertex_count = count_in;
                  end
                  ACT_QUERY: begin
                     if (count_ff < TWO) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        // Prime with the last vertex so the closing edge comes first.
                        rd_en           = 1'b1;
                        rd_addr         = last_idx[ADDR_W-1:0];
                        idx_in          = '0;
                        edge_clear      = 1'b1;
                        state_in        = ST_WALK;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in            = '0;
                     rsp_in.vertex_count = '0;
                     rsp_strobe_in       = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_en = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + ONE;
            end
         end
         ST_DRAIN: begin
            // Hold until the last read has passed every pipe stage.
            if (!rd_vld_ff && !edge_status.pending) begin
               rsp_strobe_in     = 1'b1;
               rsp_in.inside_res = edge_status.parity;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rd_first_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         rd_vld_ff     <= rd_en;
         rd_first_ff   <= rd_en && (state_ff == ST_IDLE);
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      pt_x_ff <= pt_x_in;
      pt_y_ff <= pt_y_in;
      rsp_ff  <= rsp_in;
   end

   pip_vertex_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (VERT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_data.coord_x, req_data.coord_y}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign edge_ctrl.clear = edge_clear;
   assign edge_ctrl.valid = rd_vld_ff;
   assign edge_ctrl.first = rd_first_ff;

   pip_edge_unit u_edge (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (edge_ctrl),
      .vert_x (rd_data[VERT_W-1:COORD_BITS]),
      .vert_y (rd_data[COORD_BITS-1:0]),
      .pt_x   (pt_x_ff),
      .pt_y   (pt_y_ff),
      .status (edge_status)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

### hdl/pip_vertex_ram.sv
`default_nettype none
module pip_vertex_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/pip_edge_unit.sv
`default_nettype none
module pip_edge_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  pip_pkg::edge_ctrl_type           ctrl,
   input  logic signed [pip_pkg::COORD_BITS-1:0] vert_x,
   input  logic signed [pip_pkg::COORD_BITS-1:0] vert_y,
   input  logic signed [pip_pkg::COORD_BITS-1:0] pt_x,
   input  logic signed [pip_pkg::COORD_BITS-1:0] pt_y,
   output pip_pkg::edge_status_type         status
);
   import pip_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int PROD_W = 2 * DIFF_W;

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   logic                     s1_vld_ff, s1_vld_in;
   logic                     s1_win_ff, s1_win_in;
   logic                     s1_pos_ff, s1_pos_in;
   logic signed [DIFF_W-1:0] s1_da_ff, s1_da_in;   // x - x1
   logic signed [DIFF_W-1:0] s1_db_ff, s1_db_in;   // y2 - y1
   logic signed [DIFF_W-1:0] s1_dc_ff, s1_dc_in;   // y - y1
   logic signed [DIFF_W-1:0] s1_dd_ff, s1_dd_in;   // x2 - x1

   logic                     s2_vld_ff;
   logic                     s2_win_ff;
   logic                     s2_pos_ff;
   logic signed [PROD_W-1:0] s2_lhs_ff, s2_lhs_in;
   logic signed [PROD_W-1:0] s2_rhs_ff, s2_rhs_in;

   logic flag_ff, flag_in;

   logic signed [COORD_BITS-1:0] y_hi, y_lo, x_hi;
   logic                         less;

   // Stage 1: edge window and differences.
   always_comb begin
      y_hi = (prev_y_ff > vert_y) ? prev_y_ff : vert_y;
      y_lo = (prev_y_ff > vert_y) ? vert_y : prev_y_ff;
      x_hi = (prev_x_ff > vert_x) ? prev_x_ff : vert_x;
      s1_vld_in = ctrl.valid && !ctrl.first;
      s1_win_in = (pt_y <= y_hi) && (pt_y > y_lo) && (pt_x < x_hi);
      s1_pos_in = vert_y > prev_y_ff;
      s1_da_in  = {pt_x[COORD_BITS-1], pt_x} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
      s1_db_in  = {vert_y[COORD_BITS-1], vert_y} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
      s1_dc_in  = {pt_y[COORD_BITS-1], pt_y} - {prev_y_ff[COORD_BITS-1], prev_y_ff};
      s1_dd_in  = {vert_x[COORD_BITS-1], vert_x} - {prev_x_ff[COORD_BITS-1], prev_x_ff};
   end

   // Stage 2: exact cross products.
   always_comb begin
      s2_lhs_in = s1_da_ff * s1_db_ff;
      s2_rhs_in = s1_dc_ff * s1_dd_ff;
   end

   // Stage 3: compare with direction set by the sign of dy, then toggle.
   always_comb begin
      less    = s2_pos_ff ? (s2_lhs_ff < s2_rhs_ff) : (s2_rhs_ff < s2_lhs_ff);
      flag_in = flag_ff;
      if (ctrl.clear) begin
         flag_in = 1'b0;
      end else if (s2_vld_ff && s2_win_ff && less) begin
         flag_in = !flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         flag_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
         flag_ff   <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         prev_x_ff <= vert_x;
         prev_y_ff <= vert_y;
      end
      s1_win_ff <= s1_win_in;
      s1_pos_ff <= s1_pos_in;
      s1_da_ff  <= s1_da_in;
      s1_db_ff  <= s1_db_in;
      s1_dc_ff  <= s1_dc_in;
      s1_dd_ff  <= s1_dd_in;
      s2_win_ff <= s1_win_ff;
      s2_pos_ff <= s1_pos_ff;
      s2_lhs_ff <= s2_lhs_in;
      s2_rhs_ff <= s2_rhs_in;
   end

   assign status.pending = s1_vld_ff || s2_vld_ff;
   assign status.parity  = flag_ff;

endmodule
`default_nettype wire

### hdl/pip_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pip_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input pip_pkg::req_type req_data,
   input logic             rsp_strobe,
   input pip_pkg::rsp_type rsp_data
);
   import pip_pkg::*;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

   logic quick_xfer;
   assign quick_xfer = start && !busy && (req_data.action != ACT_QUERY);

   `ASSERT_NEXT(a_quick_answer, clock, reset, quick_xfer, rsp_strobe && !busy)
   `ASSERT_IMPLY(a_count_bound, clock, reset, rsp_strobe, rsp_data.vertex_count <= MAX_COUNT)
   `ASSERT_IMPLY(a_ovf_full, clock, reset, rsp_strobe && rsp_data.overflow, rsp_data.vertex_count == MAX_COUNT)
   `ASSERT_IMPLY(a_inside_needs_edges, clock, reset, rsp_strobe && rsp_data.inside_res, rsp_data.vertex_count >= TWO)

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
`default_nettype wire
